// ===== sv/nps3d_pkg.sv =====
// Shared types for the nearest point search block.
`timescale 1ns / 1ps
package nps3d_pkg;

  // Item kinds on the input tuser
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  // Result status on the output tuser
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_DRAIN = 2'd2,
    S_DONE  = 2'd3
  } state_e;

endpackage

// ===== sv/nps3d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nps3d_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/nps3d_dist.sv =====
// Pipelined squared-distance unit: difference, square, sum; one point per cycle.
`timescale 1ns / 1ps
module nps3d_dist #(
  parameter int COORD_BITS = 16,
  parameter int IDX_W = 10,
  localparam int DIST_W = 2 * COORD_BITS + 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [IDX_W-1:0]        idx_i,
  input  logic [3*COORD_BITS-1:0] point_i,  // x, y, z from the lowest bit up
  input  logic [3*COORD_BITS-1:0] query_i,  // x, y, z from the lowest bit up
  output logic                    valid_o,
  output logic [IDX_W-1:0]        idx_o,
  output logic [DIST_W-1:0]       dist_o
);

  localparam int DW = COORD_BITS + 1;

  logic [DW-1:0]     adiff_d [3];
  logic [DW-1:0]     adiff_q [3];
  logic [DIST_W-1:0] sq_q [3];
  logic [DIST_W-1:0] sum_q;
  logic [2:0]        valid_q;
  logic [IDX_W-1:0]  idx1_q, idx2_q, idx3_q;

  // absolute per-axis differences
  always_comb begin
    logic signed [DW-1:0] p, q, d;
    for (int k = 0; k < 3; k++) begin
      p = signed'({point_i[k*COORD_BITS+COORD_BITS-1], point_i[k*COORD_BITS +: COORD_BITS]});
      q = signed'({query_i[k*COORD_BITS+COORD_BITS-1], query_i[k*COORD_BITS +: COORD_BITS]});
      d = p - q;
      adiff_d[k] = d[DW-1] ? DW'(-d) : DW'(d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= idx_i;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    for (int k = 0; k < 3; k++) begin
      adiff_q[k] <= adiff_d[k];
      sq_q[k]    <= DIST_W'(adiff_q[k]) * DIST_W'(adiff_q[k]);
    end
    sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
  end

  assign valid_o = valid_q[2];
  assign idx_o   = idx3_q;
  assign dist_o  = sum_q;

endmodule

// ===== sv/nearest_point_search_3d.sv =====
// Top level of the 3D nearest point search block.
`timescale 1ns / 1ps
// Nearest point search over a store of up to MAX_POINTS 3D points.
// Input channel s_axis: tuser carries the command (clear, load, query),
// tdata the x, y, z coordinates. Output channel m_axis: tuser carries the
// status, tdata the nearest index, squared distance and stored count.
// Every item gives exactly one result item.
// Clear and load answer at once: the result sits in the output
// register on the cycle after the item is taken.
// A query streams the stored points out of the point RAM one per cycle
// into a pipelined distance unit and keeps the running minimum (strict
// less-than, so ties keep the lowest index). No new item is taken until
// the query's result has been placed in the output register. A query on
// an empty store answers like clear and load, with the empty status.
// s_axis_tready is high only while the sequencer is idle and the output
// register is free or being taken; a stalled receiver holds the result in
// the output register and stops new items. Reset empties the store (count
// zero) and drops any pending result; RAM contents are left as they are.
module nearest_point_search_3d
  import nps3d_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16,
  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CNT_W  = $clog2(MAX_POINTS + 1),
  localparam int DIST_W = 2 * COORD_BITS + 2,
  localparam int IN_DW  = ((3 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((IDX_W + DIST_W + CNT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // coord_x, coord_y, coord_z, zero pad
  input  logic [1:0]        s_axis_tuser,   // command
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // nearest_index, nearest_sq_dist,
                                            // stored_count, zero pad
  output logic [1:0]        m_axis_tuser    // status
);

  localparam int PW = 3 * COORD_BITS;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  scan_q, scan_d;
  logic [PW-1:0]     qpt_q, qpt_d;
  logic [DIST_W-1:0] best_dist_q, best_dist_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic              rd_valid_q;
  logic [IDX_W-1:0]  rd_idx_q;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [DIST_W-1:0] out_dist_q, out_dist_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  logic              accept;
  logic              out_free;
  logic              full;
  logic [CNT_W-1:0]  count_m1;
  logic [IDX_W-1:0]  last_idx;
  logic              ram_we;
  logic              ram_re;
  logic [PW-1:0]     ram_rdata;
  logic              dist_valid;
  logic [IDX_W-1:0]  dist_idx;
  logic [DIST_W-1:0] dist_val;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CNT_W'(MAX_POINTS));
  assign count_m1      = count_q - CNT_W'(1);
  assign last_idx      = count_m1[IDX_W-1:0];

  // Point store: written at the fill count, read by the scan counter
  nps3d_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(s_axis_tdata[PW-1:0]),
    .re_i   (ram_re),
    .raddr_i(scan_q),
    .rdata_o(ram_rdata)
  );

  nps3d_dist #(
    .COORD_BITS(COORD_BITS),
    .IDX_W     (IDX_W)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(rd_valid_q),
    .idx_i  (rd_idx_q),
    .point_i(ram_rdata),
    .query_i(qpt_q),
    .valid_o(dist_valid),
    .idx_o  (dist_idx),
    .dist_o (dist_val)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_d       = scan_q;
    qpt_d        = qpt_q;
    best_dist_d  = best_dist_q;
    best_idx_d   = best_idx_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_dist_d   = out_dist_q;
    out_cnt_d    = out_cnt_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    // running minimum; first point seeds it, strict compare keeps lowest index
    if (dist_valid && ((dist_idx == '0) || (dist_val < best_dist_q))) begin
      best_dist_d = dist_val;
      best_idx_d  = dist_idx;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_OK;
          out_idx_d    = '0;
          out_dist_d   = '0;
          out_cnt_d    = count_q;
          unique case (s_axis_tuser)
            CMD_CLEAR: begin
              count_d   = '0;
              out_cnt_d = '0;
            end
            CMD_LOAD: begin
              if (full) begin
                out_status_d = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                count_d   = count_q + CNT_W'(1);
                out_cnt_d = count_q + CNT_W'(1);
              end
            end
            CMD_QUERY: begin
              if (count_q == '0) begin
                out_status_d = STAT_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                qpt_d       = s_axis_tdata[PW-1:0];
                scan_d      = '0;
                state_d     = S_SCAN;
              end
            end
            default: begin
              // unused command: no change, plain ok answer
            end
          endcase
        end
      end
      S_SCAN: begin
        ram_re = 1'b1;
        if (scan_q == last_idx) begin
          state_d = S_DRAIN;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (dist_valid && (dist_idx == last_idx)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_OK;
          out_idx_d    = best_idx_q;
          out_dist_d   = best_dist_q;
          out_cnt_d    = count_q;
          state_d      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      rd_valid_q  <= ram_re;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qpt_q        <= qpt_d;
    best_dist_q  <= best_dist_d;
    best_idx_q   <= best_idx_d;
    rd_idx_q     <= scan_q;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_dist_q   <= out_dist_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_DW'({out_cnt_q, out_dist_q, out_idx_q});

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count above capacity");

  a_scan_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CNT_W'(scan_q) < count_q))
    else $error("scan reads beyond stored points");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == STAT_FULL)) |-> (out_cnt_q == CNT_W'(MAX_POINTS)))
    else $error("full status with room left");

  a_dist_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_valid |-> ((state_q == S_SCAN) || (state_q == S_DRAIN)))
    else $error("distance result outside a query");

  a_done_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> !s_axis_tready)
    else $error("input taken while a query result is pending");
`endif

endmodule

// ===== bench/nearest_point_search_3d_test.sv =====
// Self-checking testbench for the 3D nearest point search block.
`timescale 1ns / 1ps
module nearest_point_search_3d_test;
  import nps3d_pkg::*;

  localparam int          STORE_DEPTH = 1024;
  localparam int          STALL_LIMIT = 8000;  // cycles with no item moving
  localparam int          RX_HOLD_LEN = 300;   // long receiver hold-off
  localparam logic [1:0]  CMD_SPARE   = 2'd3;  // unused command, must be a no-op
  localparam logic [15:0] C_MIN       = 16'sh8000;
  localparam logic [15:0] C_MAX       = 16'sh7fff;

  typedef struct {
    status_e     status;
    logic [9:0]  index;
    logic [33:0] sq_dist;
    logic [10:0] count;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // coord_x, coord_y, coord_z
  logic [1:0]  s_axis_tuser;   // command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // nearest_index, nearest_sq_dist, stored_count, pad
  logic [1:0]  m_axis_tuser;   // status

  // Shadow copy of the point store
  logic signed [15:0] shadow_x [STORE_DEPTH];
  logic signed [15:0] shadow_y [STORE_DEPTH];
  logic signed [15:0] shadow_z [STORE_DEPTH];
  int                 shadow_count;

  result_t pending_results[$];
  int      mismatches;
  bit      tx_idle_en;
  bit      rx_idle_en;
  int      rx_hold_reqs;
  int      rx_hold_seen;
  int      rx_hold_cycles;
  int      quiet_cycles;

  nearest_point_search_3d DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Apply one item to the shadow store and work out the result it should give.
  // Exhaustive scan with strict less-than, so ties keep the lowest index.
  function automatic result_t nearest_result(logic [1:0] cmd, logic signed [15:0] x,
                                             logic signed [15:0] y, logic signed [15:0] z);
    result_t r;
    longint  dx, dy, dz, d, best;
    int      best_idx;
    r.status  = STAT_OK;
    r.index   = '0;
    r.sq_dist = '0;
    case (cmd)
      CMD_CLEAR: begin
        shadow_count = 0;
      end
      CMD_LOAD: begin
        if (shadow_count >= STORE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_x[shadow_count] = x;
          shadow_y[shadow_count] = y;
          shadow_z[shadow_count] = z;
          shadow_count++;
        end
      end
      CMD_QUERY: begin
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          best     = -1;
          best_idx = 0;
          for (int i = 0; i < shadow_count; i++) begin
            dx = longint'(x) - longint'(shadow_x[i]);
            dy = longint'(y) - longint'(shadow_y[i]);
            dz = longint'(z) - longint'(shadow_z[i]);
            d  = dx * dx + dy * dy + dz * dz;
            if (best < 0 || d < best) begin
              best     = d;
              best_idx = i;
            end
          end
          r.index   = best_idx[9:0];
          r.sq_dist = best[33:0];
        end
      end
      default: ;  // spare command leaves everything alone
    endcase
    r.count = shadow_count[10:0];
    return r;
  endfunction

  // Offer one item at a falling edge, hold it until taken, then log what it should produce.
  task automatic send_item(logic [1:0] cmd, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    @(negedge clk_i);
    while (tx_idle_en && $urandom_range(99) < 18) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(nearest_result(cmd, x, y, z));
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (rx_hold_reqs != rx_hold_seen) begin
      rx_hold_seen   = rx_hold_reqs;
      rx_hold_cycles = RX_HOLD_LEN;
    end
    if (!rst_ni) begin
      m_axis_tready = 1'b0;
    end else if (rx_hold_cycles > 0) begin
      m_axis_tready  = 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else begin
      m_axis_tready = !(rx_idle_en && $urandom_range(99) < 18);
    end
  end

  // Compare every result item with the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result item with nothing expected: status %0d tdata %h",
                   $realtime, m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser != want.status || m_axis_tdata[9:0] != want.index ||
            m_axis_tdata[43:10] != want.sq_dist || m_axis_tdata[54:44] != want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: mismatch: expected status %0d index %0d dist %0d count %0d,",
                      " got status %0d index %0d dist %0d count %0d"},
                     $realtime, want.status, want.index, want.sq_dist, want.count,
                     m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[43:10],
                     m_axis_tdata[54:44]);
        end
      end
    end
  end

  // Watchdog on cycles where neither side moves an item
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("nearest_point_search_3d_test: errors");
      $finish;
    end
  end

  // Mostly full range, with small values and the extremes mixed in.
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(20)) - 16'd10;
      1:       return $urandom_range(1) ? C_MAX : C_MIN;
      default: return 16'($urandom);
    endcase
  endfunction

  // Empty store, unused command, extreme coordinates, largest distance, ties.
  task automatic test_edge_cases();
    send_item(CMD_QUERY, '0, '0, '0);                 // query on empty store
    send_item(CMD_SPARE, C_MAX, C_MAX, C_MAX);
    send_item(CMD_LOAD, C_MIN, C_MIN, C_MIN);
    send_item(CMD_LOAD, C_MAX, C_MAX, C_MAX);
    send_item(CMD_QUERY, C_MAX, C_MAX, C_MAX);
    send_item(CMD_QUERY, C_MIN, C_MIN, C_MIN);
    send_item(CMD_LOAD, C_MAX, C_MAX, C_MAX);         // duplicate: tie must keep index 1
    send_item(CMD_QUERY, C_MAX, C_MAX, C_MAX);
    send_item(CMD_SPARE, C_MIN, C_MIN, C_MIN);
    send_item(CMD_CLEAR, C_MAX, C_MIN, C_MAX);
    send_item(CMD_QUERY, '0, '0, '0);                 // empty again after clear
    send_item(CMD_LOAD, C_MIN, C_MIN, C_MIN);
    send_item(CMD_QUERY, C_MAX, C_MAX, C_MAX);        // largest possible distance
    send_item(CMD_CLEAR, '0, '0, '0);
    // three points equidistant from the origin
    send_item(CMD_LOAD, 16'sd100, '0, '0);
    send_item(CMD_LOAD, -16'sd100, '0, '0);
    send_item(CMD_LOAD, '0, 16'sd100, '0);
    send_item(CMD_QUERY, '0, '0, '0);
    send_item(CMD_QUERY, '0, -16'sd1, '0);
    send_item(CMD_QUERY, '0, '0, 16'sd100);
    send_item(CMD_CLEAR, '0, '0, '0);
  endtask

  // Receiver stops for a long stretch while items keep coming.
  task automatic test_backpressure();
    rx_hold_reqs++;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2)
        send_item(CMD_QUERY, pick_coord(), pick_coord(), pick_coord());
      else
        send_item(CMD_LOAD, pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  // Load bursts and queries on small stores, with clears and spare commands as noise.
  task automatic test_random_traffic();
    int          sent;
    int          pick;
    int          src;
    logic [15:0] qx, qy, qz;
    sent = 0;
    while (sent < 520) begin
      // a long run with neither side idling
      tx_idle_en = !(sent >= 200 && sent < 320);
      rx_idle_en = tx_idle_en;
      pick = $urandom_range(99);
      if (pick < 7 || shadow_count > 48) begin
        send_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end else if (pick < 11) begin
        send_item(CMD_SPARE, 16'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end else if (pick < 45) begin
        repeat ($urandom_range(1, 6)) begin
          if (shadow_count > 0 && $urandom_range(99) < 15) begin
            src = $urandom_range(shadow_count - 1);
            send_item(CMD_LOAD, shadow_x[src], shadow_y[src], shadow_z[src]);
          end else begin
            send_item(CMD_LOAD, pick_coord(), pick_coord(), pick_coord());
          end
          sent++;
        end
      end else begin
        if (shadow_count > 0 && $urandom_range(99) < 40) begin
          // near or on a stored point
          src = $urandom_range(shadow_count - 1);
          qx  = shadow_x[src] + 16'($urandom_range(2)) - 16'd1;
          qy  = shadow_y[src] + 16'($urandom_range(2)) - 16'd1;
          qz  = shadow_z[src];
        end else begin
          qx = pick_coord();
          qy = pick_coord();
          qz = pick_coord();
        end
        send_item(CMD_QUERY, qx, qy, qz);
        sent++;
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = CMD_CLEAR;
    shadow_count   = 0;
    rx_hold_reqs   = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_edge_cases();
    test_backpressure();
    test_random_traffic();

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    // watchdog bounds this wait
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("nearest_point_search_3d_test: clean");
    else
      $display("nearest_point_search_3d_test: errors");
    $finish;
  end

endmodule
